### sv/mrut_pkg.sv
// Package: shared types, constants and code tables for the MacRoman/UTF-8 transcoder.
package mrut_pkg;

   localparam logic [7:0] CH_DLE      = 8'h11;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] HI_BASE     = 8'h80;
   localparam int         QDEPTH      = 2;

   // One decoded job for the back part: up to three bytes to send.
   typedef struct packed {
      logic [1:0]  count;   // number of bytes, 1..3
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
   } job_type;

   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } seq_type;

   // ROM of the UTF-8 sequences for MacRoman 0x80..0xFF; b2 == 0 means two bytes.
   function automatic seq_type rom_seq(input logic [6:0] idx);
      seq_type s;
      unique case (idx)
         7'd0:   s = '{8'hc3,8'h84,8'h00};  7'd1:   s = '{8'hc3,8'h85,8'h00};
         7'd2:   s = '{8'hc3,8'h87,8'h00};  7'd3:   s = '{8'hc3,8'h89,8'h00};
         7'd4:   s = '{8'hc3,8'h91,8'h00};  7'd5:   s = '{8'hc3,8'h96,8'h00};
         7'd6:   s = '{8'hc3,8'h9c,8'h00};  7'd7:   s = '{8'hc3,8'ha1,8'h00};
         7'd8:   s = '{8'hc3,8'ha0,8'h00};  7'd9:   s = '{8'hc3,8'ha2,8'h00};
         7'd10:  s = '{8'hc3,8'ha4,8'h00};  7'd11:  s = '{8'hc3,8'ha3,8'h00};
         7'd12:  s = '{8'hc3,8'ha5,8'h00};  7'd13:  s = '{8'hc3,8'ha7,8'h00};
         7'd14:  s = '{8'hc3,8'ha9,8'h00};  7'd15:  s = '{8'hc3,8'ha8,8'h00};
         7'd16:  s = '{8'hc3,8'haa,8'h00};  7'd17:  s = '{8'hc3,8'hab,8'h00};
         7'd18:  s = '{8'hc3,8'had,8'h00};  7'd19:  s = '{8'hc3,8'hac,8'h00};
         7'd20:  s = '{8'hc3,8'hae,8'h00};  7'd21:  s = '{8'hc3,8'haf,8'h00};
         7'd22:  s = '{8'hc3,8'hb1,8'h00};  7'd23:  s = '{8'hc3,8'hb3,8'h00};
         7'd24:  s = '{8'hc3,8'hb2,8'h00};  7'd25:  s = '{8'hc3,8'hb4,8'h00};
         7'd26:  s = '{8'hc3,8'hb6,8'h00};  7'd27:  s = '{8'hc3,8'hb5,8'h00};
         7'd28:  s = '{8'hc3,8'hba,8'h00};  7'd29:  s = '{8'hc3,8'hb9,8'h00};
         7'd30:  s = '{8'hc3,8'hbb,8'h00};  7'd31:  s = '{8'hc3,8'hbc,8'h00};
         7'd32:  s = '{8'he2,8'h80,8'ha0};  7'd33:  s = '{8'hc2,8'hb0,8'h00};
         7'd34:  s = '{8'hc2,8'ha2,8'h00};  7'd35:  s = '{8'hc2,8'ha3,8'h00};
         7'd36:  s = '{8'hc2,8'ha7,8'h00};  7'd37:  s = '{8'he2,8'h80,8'ha2};
         7'd38:  s = '{8'hc2,8'hb6,8'h00};  7'd39:  s = '{8'hc3,8'h9f,8'h00};
         7'd40:  s = '{8'hc2,8'hae,8'h00};  7'd41:  s = '{8'hc2,8'ha9,8'h00};
         7'd42:  s = '{8'he2,8'h84,8'ha2};  7'd43:  s = '{8'hc2,8'hb4,8'h00};
         7'd44:  s = '{8'hc2,8'ha8,8'h00};  7'd45:  s = '{8'he2,8'h89,8'ha0};
         7'd46:  s = '{8'hc3,8'h86,8'h00};  7'd47:  s = '{8'hc3,8'h98,8'h00};
         7'd48:  s = '{8'he2,8'h88,8'h9e};  7'd49:  s = '{8'hc2,8'hb1,8'h00};
         7'd50:  s = '{8'he2,8'h89,8'ha4};  7'd51:  s = '{8'he2,8'h89,8'ha5};
         7'd52:  s = '{8'hc2,8'ha5,8'h00};  7'd53:  s = '{8'hc2,8'hb5,8'h00};
         7'd54:  s = '{8'he2,8'h88,8'h82};  7'd55:  s = '{8'he2,8'h88,8'h91};
         7'd56:  s = '{8'he2,8'h88,8'h8f};  7'd57:  s = '{8'hcf,8'h80,8'h00};
         7'd58:  s = '{8'he2,8'h88,8'hab};  7'd59:  s = '{8'hc2,8'haa,8'h00};
         7'd60:  s = '{8'hc2,8'hba,8'h00};  7'd61:  s = '{8'hce,8'ha9,8'h00};
         7'd62:  s = '{8'hc3,8'ha6,8'h00};  7'd63:  s = '{8'hc3,8'hb8,8'h00};
         7'd64:  s = '{8'hc2,8'hbf,8'h00};  7'd65:  s = '{8'hc2,8'ha1,8'h00};
         7'd66:  s = '{8'hc2,8'hac,8'h00};  7'd67:  s = '{8'he2,8'h88,8'h9a};
         7'd68:  s = '{8'hc6,8'h92,8'h00};  7'd69:  s = '{8'he2,8'h89,8'h88};
         7'd70:  s = '{8'he2,8'h88,8'h86};  7'd71:  s = '{8'hc2,8'hab,8'h00};
         7'd72:  s = '{8'hc2,8'hbb,8'h00};  7'd73:  s = '{8'he2,8'h80,8'ha6};
         7'd74:  s = '{8'hc2,8'ha0,8'h00};  7'd75:  s = '{8'hc3,8'h80,8'h00};
         7'd76:  s = '{8'hc3,8'h83,8'h00};  7'd77:  s = '{8'hc3,8'h95,8'h00};
         7'd78:  s = '{8'hc5,8'h92,8'h00};  7'd79:  s = '{8'hc5,8'h93,8'h00};
         7'd80:  s = '{8'he2,8'h80,8'h93};  7'd81:  s = '{8'he2,8'h80,8'h94};
         7'd82:  s = '{8'he2,8'h80,8'h9c};  7'd83:  s = '{8'he2,8'h80,8'h9d};
         7'd84:  s = '{8'he2,8'h80,8'h98};  7'd85:  s = '{8'he2,8'h80,8'h99};
         7'd86:  s = '{8'hc3,8'hb7,8'h00};  7'd87:  s = '{8'he2,8'h97,8'h8a};
         7'd88:  s = '{8'hc3,8'hbf,8'h00};  7'd89:  s = '{8'hc5,8'hb8,8'h00};
         7'd90:  s = '{8'he2,8'h81,8'h84};  7'd91:  s = '{8'he2,8'h82,8'hac};
         7'd92:  s = '{8'he2,8'h80,8'hb9};  7'd93:  s = '{8'he2,8'h80,8'hba};
         7'd94:  s = '{8'hef,8'hac,8'h81};  7'd95:  s = '{8'hef,8'hac,8'h82};
         7'd96:  s = '{8'he2,8'h80,8'ha1};  7'd97:  s = '{8'hc2,8'hb7,8'h00};
         7'd98:  s = '{8'he2,8'h80,8'h9a};  7'd99:  s = '{8'he2,8'h80,8'h9e};
         7'd100: s = '{8'he2,8'h80,8'hb0};  7'd101: s = '{8'hc3,8'h82,8'h00};
         7'd102: s = '{8'hc3,8'h8a,8'h00};  7'd103: s = '{8'hc3,8'h81,8'h00};
         7'd104: s = '{8'hc3,8'h8b,8'h00};  7'd105: s = '{8'hc3,8'h88,8'h00};
         7'd106: s = '{8'hc3,8'h8d,8'h00};  7'd107: s = '{8'hc3,8'h8e,8'h00};
         7'd108: s = '{8'hc3,8'h8f,8'h00};  7'd109: s = '{8'hc3,8'h8c,8'h00};
         7'd110: s = '{8'hc3,8'h93,8'h00};  7'd111: s = '{8'hc3,8'h94,8'h00};
         7'd112: s = '{8'hef,8'ha3,8'hbf};  7'd113: s = '{8'hc3,8'h92,8'h00};
         7'd114: s = '{8'hc3,8'h9a,8'h00};  7'd115: s = '{8'hc3,8'h9b,8'h00};
         7'd116: s = '{8'hc3,8'h99,8'h00};  7'd117: s = '{8'hc4,8'hb1,8'h00};
         7'd118: s = '{8'hcb,8'h86,8'h00};  7'd119: s = '{8'hcb,8'h9c,8'h00};
         7'd120: s = '{8'hc2,8'haf,8'h00};  7'd121: s = '{8'hcb,8'h98,8'h00};
         7'd122: s = '{8'hcb,8'h99,8'h00};  7'd123: s = '{8'hcb,8'h9a,8'h00};
         7'd124: s = '{8'hc2,8'hb8,8'h00};  7'd125: s = '{8'hcb,8'h9d,8'h00};
         7'd126: s = '{8'hcb,8'h9b,8'h00};  default: s = '{8'hcb,8'h87,8'h00};
      endcase
      return s;
   endfunction

   function automatic logic [7:0] swap_crlf(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b == CH_CR) r = CH_LF;
      else if (b == CH_LF) r = CH_CR;
      return r;
   endfunction

   // Match result of a buffer prefix against the ROM.
   typedef struct packed {
      logic       full;     // complete match of flen bytes
      logic [1:0] flen;     // length consumed by the full match
      logic [6:0] fidx;     // lowest index of the full match
      logic       partial;  // some longer sequence starts with these bytes
   } match_type;

   // Compare up to len bytes of buf against every ROM entry in parallel.
   function automatic match_type rom_match(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2, input logic [1:0] len);
      match_type m;
      seq_type   s;
      logic      three;
      logic      eq;
      m = '0;
      for (int i = 127; i >= 0; i--) begin
         s = rom_seq(7'(i));
         three = (s.b2 != 8'h00);
         eq = (s.b0 == c0) && (len < 2'd2 || s.b1 == c1) &&
              (len < 2'd3 || !three || s.b2 == c2);
         if (eq) begin
            if ((three ? 2'd3 : 2'd2) <= len) begin
               m.full = 1'b1;
               m.fidx = 7'(i);
               m.flen = three ? 2'd3 : 2'd2;
            end else begin
               m.partial = 1'b1;
            end
         end
      end
      return m;
   endfunction

endpackage

### sv/mrut_stream_if.sv
// Interfaces: request, response and control-register write channels.
interface mrut_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;
   modport source (output valid, in_byte, end_of_text, input ready);
   modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface mrut_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   modport source (output valid, out_byte, last_of_run, input ready);
   modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

interface mrut_csr_if;
   logic valid;
   logic ready;
   logic direction;
   modport source (output valid, direction, input ready);
   modport sink   (input valid, direction, output ready);
endinterface

### sv/mrut_front.sv
// Front part: takes requests, resolves the held prefix, and forms output jobs.
module mrut_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            direction,
   mrut_req_if.sink        req,
   output logic            job_valid,
   output mrut_pkg::job_type job,
   input  logic            job_ready
);
   import mrut_pkg::*;

   // Prefix bytes hold no reset; count says which are meaningful.
   logic [7:0] pfx0_ff, pfx0_in, pfx1_ff, pfx1_in;
   logic [1:0] pcnt_ff, pcnt_in;

   // Work buffer for one step; in the MacRoman direction it is resolved in up to
   // three peel stages, each emitting at most one byte, all in combinational logic.
   logic [7:0] bf [3];
   logic [7:0] emit [3];
   logic [1:0] nemit;

   always_comb begin
      logic [7:0] c0, c1, c2;
      logic [1:0] len;
      logic       stop;
      match_type  m;
      seq_type    s;
      c0 = pfx0_ff; c1 = pfx1_ff; c2 = req.in_byte; len = 2'd0;
      stop = 1'b0;
      m = '0;
      emit[0] = '0; emit[1] = '0; emit[2] = '0;
      nemit = 2'd0;
      pfx0_in = pfx0_ff; pfx1_in = pfx1_ff; pcnt_in = pcnt_ff;
      bf[0] = '0; bf[1] = '0; bf[2] = '0;
      s = rom_seq(req.in_byte[6:0]);
      if (!direction) begin
         if (req.in_byte[7]) begin
            emit[0] = s.b0; emit[1] = s.b1; emit[2] = s.b2;
            nemit = (s.b2 != 8'h00) ? 2'd3 : 2'd2;
         end else if (req.in_byte == CH_DLE) begin
            emit[0] = 8'hE2; emit[1] = 8'h8C; emit[2] = 8'h98; nemit = 2'd3;
         end else if (req.in_byte != CH_NUL) begin
            emit[0] = swap_crlf(req.in_byte); nemit = 2'd1;
         end
      end else begin
         // Pack the held prefix and the new byte into one buffer.
         unique case (pcnt_ff)
            2'd0:    begin bf[0] = req.in_byte; len = 2'd1; end
            2'd1:    begin bf[0] = pfx0_ff; bf[1] = req.in_byte; len = 2'd2; end
            default: begin
               bf[0] = pfx0_ff; bf[1] = pfx1_ff; bf[2] = req.in_byte; len = 2'd3;
            end
         endcase
         c0 = bf[0]; c1 = bf[1]; c2 = bf[2];
         for (int k = 0; k < 3; k++) begin
            m = rom_match(c0, c1, c2, len);
            if (!stop && len != 2'd0) begin
               if (!c0[7]) begin
                  emit[nemit] = swap_crlf(c0); nemit = nemit + 2'd1;
                  c0 = c1; c1 = c2; len = len - 2'd1;
               end else if (m.full) begin
                  emit[nemit] = HI_BASE | {1'b0, m.fidx}; nemit = nemit + 2'd1;
                  if (m.flen == 2'd3) begin len = 2'd0; end
                  else begin c0 = c2; len = len - 2'd2; end
               end else if (m.partial && !req.end_of_text) begin
                  stop = 1'b1;
               end else begin
                  emit[nemit] = CH_QUESTION; nemit = nemit + 2'd1;
                  c0 = c1; c1 = c2; len = len - 2'd1;
               end
            end
         end
         pfx0_in = c0; pfx1_in = c1; pcnt_in = len;
      end
   end

   // Skid-free handoff: accept when the queue has room.
   assign req.ready = job_ready;
   assign job_valid = req.valid && nemit != 2'd0;
   assign job = '{count: nemit, b0: emit[0], b1: emit[1], b2: emit[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff <= 2'd0;
      end else if (req.valid && req.ready && direction) begin
         pcnt_ff <= pcnt_in;
      end
      if (req.valid && req.ready && direction) begin
         pfx0_ff <= pfx0_in;
         pfx1_ff <= pfx1_in;
      end
   end

   // Held prefix never exceeds two bytes.
   assert property (@(posedge clock) disable iff (reset) pcnt_ff != 2'd3)
      else $error("prefix count overflow");
   // A job is never offered while the queue is full without being stalled upstream.
   assert property (@(posedge clock) disable iff (reset)
      job_valid && !job_ready |-> !(req.valid && req.ready))
      else $error("request taken while queue full");
   // Pending prefix only changes on an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      !$past(req.valid && req.ready) |-> $stable(pcnt_ff))
      else $error("prefix count moved without request");
endmodule

### sv/mrut_back.sv
// Back part: a two-entry job queue and a serializer that sends one byte a cycle while rsp is ready.
module mrut_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  mrut_pkg::job_type job,
   output logic             job_ready,
   mrut_rsp_if.source       rsp
);
   import mrut_pkg::*;

   job_type    q_ff [QDEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] pos_ff, pos_in;   // byte position inside the head job
   logic       push, pop;
   job_type    head;
   logic [7:0] sel;

   assign head = q_ff[rp_ff];
   always_comb begin
      unique case (pos_ff)
         2'd0:    sel = head.b0;
         2'd1:    sel = head.b1;
         default: sel = head.b2;
      endcase
   end

   // Ready whenever a slot is free; the head keeps draining meanwhile.
   assign job_ready = (cnt_ff != 2'(QDEPTH));
   assign push = job_valid && job_ready;
   assign rsp.valid = (cnt_ff != 2'd0);
   assign rsp.out_byte = sel;
   assign rsp.last_of_run = (pos_ff + 2'd1 == head.count);
   assign pop = rsp.valid && rsp.ready && rsp.last_of_run;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      pos_in = pos_ff;
      if (rsp.valid && rsp.ready) pos_in = pop ? 2'd0 : pos_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0; pos_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in; pos_ff <= pos_in;
      end
      if (push) q_ff[wp_ff] <= job;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QDEPTH))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> pos_ff < head.count)
      else $error("byte position beyond job");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> pos_ff == 2'd0)
      else $error("position nonzero with empty queue");
endmodule

### sv/macroman_utf8_transcoder.sv
// Top level: MacRoman/UTF-8 transcoder with control register, front and back parts.
// Results are registered in the job queue before they are sent. Throughput, while rsp
// is ready: one request per cycle while each gives one byte; the serializer sends one
// byte a cycle, so a 2 or 3 byte result holds input through the two-entry queue.
// Reset (synchronous, active high) clears direction to 0, the held prefix and queue.
module macroman_utf8_transcoder (
   input  logic       clock,
   input  logic       reset,
   mrut_req_if.sink   req,
   mrut_rsp_if.source rsp,
   mrut_csr_if.sink   csr
);
   import mrut_pkg::*;

   logic    direction_ff;
   logic    job_valid, job_ready;
   job_type job;

   // Control register
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) direction_ff <= 1'b0;
      else if (csr.valid) direction_ff <= csr.direction;
   end

   mrut_front u_front (.clock, .reset, .direction(direction_ff), .req,
                       .job_valid, .job, .job_ready);
   mrut_back  u_back  (.clock, .reset, .job_valid, .job, .job_ready, .rsp);
endmodule
